/* sv/qbr_pkg.sv */
// Shared types, constants and sizing functions of the quartic bisection root finder.
package qbr_pkg;

  localparam int CHUNK_W   = 32;
  localparam int STEP_IDXW = 3;
  localparam int NUM_REGS  = 6;

  localparam logic [2:0] REG_COEF_FOUR  = 3'd0;
  localparam logic [2:0] REG_COEF_THREE = 3'd1;
  localparam logic [2:0] REG_COEF_TWO   = 3'd2;
  localparam logic [2:0] REG_COEF_ONE   = 3'd3;
  localparam logic [2:0] REG_COEF_ZERO  = 3'd4;
  localparam logic [2:0] REG_STOP_WIDTH = 3'd5;

  localparam logic [STEP_IDXW-1:0] TERM_CUBE   = 3'd1;
  localparam logic [STEP_IDXW-1:0] TERM_SQUARE = 3'd2;
  localparam logic [STEP_IDXW-1:0] TERM_LINEAR = 3'd3;
  localparam logic [STEP_IDXW-1:0] TERM_CONST  = 3'd4;

  typedef struct packed {
    logic                 load;
    logic                 set_x;
    logic                 x_from_mid;
    logic                 eval_init;
    logic                 mul_en;
    logic [STEP_IDXW-1:0] mul_idx;
    logic                 term_add;
    logic [STEP_IDXW-1:0] term_idx;
    logic                 save_sign;
    logic                 decide;
    logic                 finish;
  } cmd_t;

  typedef struct packed {
    logic run;
    logic acc_zero;
  } status_t;

  function automatic int acc_width(input int xw, input int fb, input int cw);
    int m;
    begin
      m = (xw > fb) ? xw : fb + 1;
      return cw + 4 * m + 3;
    end
  endfunction

  function automatic int chunk_count(input int aw);
    return (aw + CHUNK_W - 1) / CHUNK_W;
  endfunction

endpackage

/* sv/qbr_ifs.sv */
// Valid/ready channel interfaces for bracket beats and result beats.
interface qbr_bracket_if #(parameter int XW = 24) ();
  logic                 valid;
  logic                 ready;
  logic signed [XW-1:0] low_end;
  logic signed [XW-1:0] high_end;
  modport source (output valid, low_end, high_end, input ready);
  modport sink (input valid, low_end, high_end, output ready);
endinterface

interface qbr_result_if #(parameter int XW = 24) ();
  localparam int CW = $clog2(XW + 1);
  logic                 valid;
  logic                 ready;
  logic signed [XW-1:0] root;
  logic [CW-1:0]        pass_count;
  logic                 exact_hit;
  modport source (output valid, root, pass_count, exact_hit, input ready);
  modport sink (input valid, root, pass_count, exact_hit, output ready);
endinterface

/* sv/quartic_bisection_root_top.sv */
// Quartic bisection root finder: top level with APB registers and beat channels.
// Each bracket first evaluates the polynomial at its low end, then runs bisection passes;
// each pass is one Horner evaluation over NC chunks, NC = 4 chunks by default;
// up to 24 passes.
// Accepts one bracket at a time; all products use the shared 33x24 chunk multiplier.
// Reset: synchronous, clears control state, coefficients to 0 and stop width to 7.
module quartic_bisection_root_top import qbr_pkg::*; #(
  parameter int X_WIDTH    = 24,
  parameter int FRAC_BITS  = 16,
  parameter int COEF_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  qbr_bracket_if.sink           bracket,
  qbr_result_if.source          result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic signed [COEF_WIDTH-1:0] coef_four, coef_three, coef_two, coef_one, coef_zero;
  logic [X_WIDTH-1:0]           stop_width;
  cmd_t                         cmd;
  status_t                      status;

  qbr_regs #(.X_WIDTH(X_WIDTH), .COEF_WIDTH(COEF_WIDTH)) u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .coef_four(coef_four), .coef_three(coef_three), .coef_two(coef_two),
    .coef_one(coef_one), .coef_zero(coef_zero), .stop_width(stop_width)
  );

  qbr_ctrl #(.X_WIDTH(X_WIDTH), .FRAC_BITS(FRAC_BITS), .COEF_WIDTH(COEF_WIDTH)) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(bracket.valid), .in_ready(bracket.ready),
    .out_valid(result.valid), .out_ready(result.ready), .status(status), .cmd(cmd)
  );

  qbr_dp #(.X_WIDTH(X_WIDTH), .FRAC_BITS(FRAC_BITS), .COEF_WIDTH(COEF_WIDTH)) u_dp (
    .clk(clk), .cmd(cmd), .status(status),
    .low_end(bracket.low_end), .high_end(bracket.high_end),
    .coef_four(coef_four), .coef_three(coef_three), .coef_two(coef_two),
    .coef_one(coef_one), .coef_zero(coef_zero), .stop_width(stop_width),
    .root(result.root), .pass_count(result.pass_count), .exact_hit(result.exact_hit)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.pass_count <= X_WIDTH)
    else $error("pass count beyond limit");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    bracket.valid && bracket.ready |=> !bracket.ready)
    else $error("accepted a bracket while busy");

  a_hit_not_counted_past_limit: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.exact_hit |-> result.pass_count < X_WIDTH)
    else $error("hit reported after last pass");

endmodule

/* sv/qbr_regs.sv */
// APB configuration registers: polynomial coefficients and stop width.
module qbr_regs import qbr_pkg::*; #(
  parameter int X_WIDTH    = 24,
  parameter int COEF_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [4:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output logic signed [COEF_WIDTH-1:0] coef_four,
  output logic signed [COEF_WIDTH-1:0] coef_three,
  output logic signed [COEF_WIDTH-1:0] coef_two,
  output logic signed [COEF_WIDTH-1:0] coef_one,
  output logic signed [COEF_WIDTH-1:0] coef_zero,
  output logic [X_WIDTH-1:0]           stop_width
);

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_four  <= '0;
      coef_three <= '0;
      coef_two   <= '0;
      coef_one   <= '0;
      coef_zero  <= '0;
      stop_width <= X_WIDTH'(7);
    end else if (wr) begin
      case (idx)
        REG_COEF_FOUR:  coef_four  <= pwdata[COEF_WIDTH-1:0];
        REG_COEF_THREE: coef_three <= pwdata[COEF_WIDTH-1:0];
        REG_COEF_TWO:   coef_two   <= pwdata[COEF_WIDTH-1:0];
        REG_COEF_ONE:   coef_one   <= pwdata[COEF_WIDTH-1:0];
        REG_COEF_ZERO:  coef_zero  <= pwdata[COEF_WIDTH-1:0];
        REG_STOP_WIDTH: stop_width <= pwdata[X_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_COEF_FOUR:  prdata = 32'(coef_four);
      REG_COEF_THREE: prdata = 32'(coef_three);
      REG_COEF_TWO:   prdata = 32'(coef_two);
      REG_COEF_ONE:   prdata = 32'(coef_one);
      REG_COEF_ZERO:  prdata = 32'(coef_zero);
      REG_STOP_WIDTH: prdata = 32'(stop_width);
      default:        prdata = '0;
    endcase
  end

endmodule

/* sv/qbr_dp.sv */
// Datapath: bracket registers, chunked Horner evaluator and result registers.
module qbr_dp import qbr_pkg::*; #(
  parameter int X_WIDTH    = 24,
  parameter int FRAC_BITS  = 16,
  parameter int COEF_WIDTH = 16
) (
  input  logic                         clk,
  input  cmd_t                         cmd,
  output status_t                      status,
  input  logic signed [X_WIDTH-1:0]    low_end,
  input  logic signed [X_WIDTH-1:0]    high_end,
  input  logic signed [COEF_WIDTH-1:0] coef_four,
  input  logic signed [COEF_WIDTH-1:0] coef_three,
  input  logic signed [COEF_WIDTH-1:0] coef_two,
  input  logic signed [COEF_WIDTH-1:0] coef_one,
  input  logic signed [COEF_WIDTH-1:0] coef_zero,
  input  logic [X_WIDTH-1:0]           stop_width,
  output logic signed [X_WIDTH-1:0]    root,
  output logic [$clog2(X_WIDTH+1)-1:0] pass_count,
  output logic                         exact_hit
);

  localparam int AW   = acc_width(X_WIDTH, FRAC_BITS, COEF_WIDTH);
  localparam int NC   = chunk_count(AW);
  localparam int PPW  = CHUNK_W + 1 + X_WIDTH;
  localparam int PW   = NC * CHUNK_W + PPW;
  localparam int CNTW = $clog2(X_WIDTH + 1);

  logic signed [X_WIDTH-1:0] a, b, m, x, cur_root;
  logic [CNTW-1:0]           count;
  logic                      hit;
  logic                      sa_neg, sa_zero;
  logic [AW-1:0]             acc, prod;
  logic signed [PPW-1:0]     pp;
  logic                      pp_vld;
  logic [STEP_IDXW-1:0]      pp_idx;

  logic signed [X_WIDTH:0]   diff;
  logic signed [X_WIDTH-1:0] mid;
  logic [NC*CHUNK_W-1:0]     acc_pad;
  logic [CHUNK_W-1:0]        chunk;
  logic [PW-1:0]             pp_ext;
  logic [PW-1:0]             pp_sh;
  logic signed [COEF_WIDTH-1:0] coef_sel;
  logic [AW-1:0]             term_ext;
  logic [AW-1:0]             term;
  logic                      acc_neg, acc_zero, opposite;

  assign diff     = {b[X_WIDTH-1], b} - {a[X_WIDTH-1], a};
  assign mid      = a + X_WIDTH'(diff >>> 1);
  assign status.run = (count < CNTW'(X_WIDTH)) &&
                      ($signed({diff[X_WIDTH], diff}) >= $signed({2'b00, stop_width}));

  assign acc_pad  = (NC*CHUNK_W)'(acc);
  assign chunk    = acc_pad[cmd.mul_idx[$clog2(NC+1)-1:0]*CHUNK_W +: CHUNK_W];
  assign pp_ext   = {{(PW-PPW){pp[PPW-1]}}, pp};
  assign pp_sh    = pp_ext << (pp_idx * CHUNK_W);

  always_comb begin
    case (cmd.term_idx)
      TERM_CUBE: begin
        coef_sel = coef_three;
      end
      TERM_SQUARE: begin
        coef_sel = coef_two;
      end
      TERM_LINEAR: begin
        coef_sel = coef_one;
      end
      TERM_CONST: begin
        coef_sel = coef_zero;
      end
      default: begin
        coef_sel = '0;
      end
    endcase
  end

  assign term_ext = {{(AW-COEF_WIDTH){coef_sel[COEF_WIDTH-1]}}, coef_sel};
  assign term     = term_ext << (cmd.term_idx * FRAC_BITS);

  assign acc_neg         = acc[AW-1];
  assign acc_zero        = (acc == '0);
  assign status.acc_zero = acc_zero;
  assign opposite        = !acc_zero && !sa_zero && (acc_neg != sa_neg);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a        <= low_end;
      b        <= high_end;
      cur_root <= low_end;
      count    <= '0;
      hit      <= 1'b0;
    end
    if (cmd.set_x) begin
      m <= mid;
      x <= cmd.x_from_mid ? mid : a;
    end
    pp_vld <= cmd.mul_en;
    pp_idx <= cmd.mul_idx;
    if (cmd.mul_en) begin
      pp <= $signed({1'b0, chunk}) * x;
    end
    if (cmd.eval_init) begin
      acc  <= {{(AW-COEF_WIDTH){coef_four[COEF_WIDTH-1]}}, coef_four};
      prod <= '0;
    end else if (cmd.term_add) begin
      acc  <= prod + term;
      prod <= '0;
    end else if (pp_vld) begin
      prod <= prod + pp_sh[AW-1:0];
    end
    if (cmd.save_sign) begin
      sa_neg  <= acc_neg;
      sa_zero <= acc_zero;
    end
    if (cmd.decide) begin
      cur_root <= m;
      if (acc_zero) begin
        hit <= 1'b1;
      end else begin
        if (opposite) begin
          b <= m;
        end else begin
          a       <= m;
          sa_neg  <= acc_neg;
          sa_zero <= 1'b0;
        end
        count <= count + 1'b1;
      end
    end
    if (cmd.finish) begin
      root       <= cur_root;
      pass_count <= count;
      exact_hit  <= hit;
    end
  end

endmodule

/* sv/qbr_ctrl.sv */
// Controller: sequences passes, Horner steps and chunk multiplies.
module qbr_ctrl import qbr_pkg::*; #(
  parameter int X_WIDTH    = 24,
  parameter int FRAC_BITS  = 16,
  parameter int COEF_WIDTH = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam int AW = acc_width(X_WIDTH, FRAC_BITS, COEF_WIDTH);
  localparam int NC = chunk_count(AW);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_INIT   = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_DRAIN  = 3'd4;
  localparam logic [2:0] S_ADD    = 3'd5;
  localparam logic [2:0] S_DECIDE = 3'd6;
  localparam logic [2:0] S_FINISH = 3'd7;

  logic [2:0]           state, state_next;
  logic [STEP_IDXW-1:0] j, j_next, k, k_next;
  logic                 sa_known, sa_known_next;
  logic                 for_a, for_a_next;
  logic                 out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next    = state;
    j_next        = j;
    k_next        = k;
    sa_known_next = sa_known;
    for_a_next    = for_a;
    cmd           = '0;
    cmd.mul_idx   = j;
    cmd.term_idx  = k;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load      = 1'b1;
          sa_known_next = 1'b0;
          state_next    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.run) begin
          cmd.set_x      = 1'b1;
          cmd.x_from_mid = sa_known;
          for_a_next     = !sa_known;
          state_next     = S_INIT;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_INIT: begin
        cmd.eval_init = 1'b1;
        j_next        = '0;
        k_next        = TERM_CUBE;
        state_next    = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        j_next     = j + 1'b1;
        if (j == STEP_IDXW'(NC - 1)) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.term_add = 1'b1;
        j_next       = '0;
        k_next       = k + 1'b1;
        state_next   = (k == TERM_CONST) ? S_DECIDE : S_MUL;
      end
      S_DECIDE: begin
        if (for_a) begin
          cmd.save_sign = 1'b1;
          sa_known_next = 1'b1;
          state_next    = S_CHECK;
        end else begin
          cmd.decide = 1'b1;
          state_next = status.acc_zero ? S_FINISH : S_CHECK;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      j         <= '0;
      k         <= '0;
      sa_known  <= 1'b0;
      for_a     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      j        <= j_next;
      k        <= k_next;
      sa_known <= sa_known_next;
      for_a    <= for_a_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
